>>> rtl/core/hstbl_pkg.sv
// Package for the hashed symbol table: sizes, widths and status codes.
// No dependencies; used by every module of the block.
`default_nettype none
package hstbl_pkg;
   localparam int BUCKETS_DEF    = 64;
   localparam int ENTRIES_DEF    = 256;
   localparam int NAME_CHARS_DEF = 16;
   localparam int CHAR_W  = 8;
   localparam int INDEX_W = 8;
   localparam int HASH_W  = 32;
   localparam logic [HASH_W-1:0] HASH_MULT = 32'd31;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_TOO_LONG = 2'd2
   } status_type;
endpackage
`default_nettype wire

>>> rtl/core/hstbl_name_acc.sv
// Name accumulator: running hash and name buffer for one symbol name.
// Depends on hstbl_pkg.
`default_nettype none
module hstbl_name_acc #(
   parameter int NAME_CHARS = hstbl_pkg::NAME_CHARS_DEF,
   parameter int LEN_W      = $clog2(NAME_CHARS + 2)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          take,
   input  wire logic [hstbl_pkg::CHAR_W-1:0]  character,
   input  wire logic                          clear,
   input  wire logic [$clog2(NAME_CHARS+1)-1:0] rd_pos,
   output logic      [hstbl_pkg::CHAR_W-1:0]  rd_char,
   output logic      [hstbl_pkg::HASH_W-1:0]  hash_next,
   output logic      [LEN_W-1:0]              len_next
);
   localparam int BI_W = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;
   logic [hstbl_pkg::HASH_W-1:0] hash_ff;
   logic [LEN_W-1:0]             len_ff;
   logic [hstbl_pkg::CHAR_W-1:0] buf_ff [NAME_CHARS];
   logic [hstbl_pkg::HASH_W-1:0] prod;

   assign prod      = hash_ff * hstbl_pkg::HASH_MULT;
   assign hash_next = prod + {{(hstbl_pkg::HASH_W-hstbl_pkg::CHAR_W){1'b0}}, character};
   assign len_next  = (len_ff <= LEN_W'(NAME_CHARS)) ? len_ff + 1'b1 : len_ff;
   assign rd_char   = buf_ff[rd_pos[BI_W-1:0]];

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         hash_ff <= '0;
         len_ff  <= '0;
      end else if (take) begin
         hash_ff <= hash_next;
         len_ff  <= len_next;
      end
      if (take && !clear && len_ff < LEN_W'(NAME_CHARS)) begin
         buf_ff[len_ff[BI_W-1:0]] <= character;
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/hstbl_engine.sv
// Chain walk and insert engine over the bucket, link, length and name memories.
// Depends on hstbl_pkg.
`default_nettype none
module hstbl_engine #(
   parameter int BUCKETS    = hstbl_pkg::BUCKETS_DEF,
   parameter int ENTRIES    = hstbl_pkg::ENTRIES_DEF,
   parameter int NAME_CHARS = hstbl_pkg::NAME_CHARS_DEF,
   parameter int LEN_W      = $clog2(NAME_CHARS + 2)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [hstbl_pkg::HASH_W-1:0]  hash,
   input  wire logic [LEN_W-1:0]              name_len,
   output logic [$clog2(NAME_CHARS+1)-1:0]    buf_pos,
   input  wire logic [hstbl_pkg::CHAR_W-1:0]  buf_char,
   output logic                               done,
   output logic [hstbl_pkg::INDEX_W-1:0]      res_index,
   output logic                               res_present,
   output hstbl_pkg::status_type              res_status
);
   localparam int BK_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int EI_W = $clog2(ENTRIES);
   localparam int NF_W = $clog2(ENTRIES + 1);
   localparam int CP_W = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;
   localparam int BP_W = $clog2(NAME_CHARS + 1);
   localparam int SC_W = $clog2(ENTRIES + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_HEAD, S_ENTRY, S_CMP, S_INS, S_HEADWR
   } state_type;

   // memories
   logic [EI_W-1:0]            heads_mem [BUCKETS];
   logic [BUCKETS-1:0]         head_valid_ff;
   logic [EI_W-1:0]            links_mem [ENTRIES];
   logic [LEN_W-1:0]           lens_mem  [ENTRIES];
   logic [hstbl_pkg::CHAR_W-1:0] chars_mem [ENTRIES*NAME_CHARS];

   state_type                  state_ff;
   logic [BK_W-1:0]            bucket_ff;
   logic [BK_W-1:0]            head_addr;
   logic [EI_W-1:0]            head_q, link_q, pos_ff;
   logic [LEN_W-1:0]           len_q, nlen_ff;
   logic [hstbl_pkg::CHAR_W-1:0] char_q;
   logic [NF_W-1:0]            next_free_ff;
   logic [SC_W-1:0]            steps_ff;
   logic [BP_W-1:0]            cp_ff;
   logic                       head_ok_ff;
   logic [hstbl_pkg::INDEX_W-1:0] res_index_ff;
   logic                       res_present_ff, done_ff;
   hstbl_pkg::status_type      res_status_ff;
   logic [EI_W-1:0]            nf_idx;
   logic [EI_W+CP_W-1:0]       rd_addr, wr_addr;

   // bucket head read is addressed from the incoming hash while idle
   assign head_addr = (state_ff == S_IDLE) ? BK_W'(hash % BUCKETS) : bucket_ff;
   assign nf_idx  = next_free_ff[EI_W-1:0];
   // compare looks at the byte that the chars memory read registered for position cp_ff-1
   assign buf_pos = (state_ff == S_CMP) ? cp_ff - BP_W'(1) : cp_ff;
   assign rd_addr = {pos_ff, cp_ff[CP_W-1:0]};
   assign wr_addr = {nf_idx, cp_ff[CP_W-1:0]};
   assign done        = done_ff;
   assign res_index   = res_index_ff;
   assign res_present = res_present_ff;
   assign res_status  = res_status_ff;

   // memory reads, registered (synchronous)
   always_ff @(posedge clock) begin
      head_q     <= heads_mem[head_addr];
      head_ok_ff <= head_valid_ff[head_addr];
      link_q     <= links_mem[pos_ff];
      len_q      <= lens_mem[pos_ff];
      char_q     <= chars_mem[rd_addr];
      if (state_ff == S_INS && cp_ff < BP_W'(nlen_ff)) begin
         chars_mem[wr_addr] <= buf_char;
      end
      if (state_ff == S_HEADWR) begin
         heads_mem[bucket_ff] <= nf_idx;
         links_mem[nf_idx]    <= head_ok_ff ? head_q : '0;
         lens_mem[nf_idx]     <= nlen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_valid_ff <= '0;
         next_free_ff  <= NF_W'(1);
         done_ff       <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  nlen_ff <= name_len;
                  if (name_len > LEN_W'(NAME_CHARS)) begin
                     res_index_ff   <= '0;
                     res_present_ff <= 1'b0;
                     res_status_ff  <= hstbl_pkg::STATUS_TOO_LONG;
                     done_ff        <= 1'b1;
                  end else begin
                     bucket_ff <= head_addr;
                     steps_ff  <= '0;
                     state_ff  <= S_HEAD;
                  end
               end
            end
            S_HEAD: begin
               // head_q valid now; pos 0 means empty chain
               pos_ff   <= head_ok_ff ? head_q : '0;
               cp_ff    <= '0;
               state_ff <= S_ENTRY;
            end
            S_ENTRY: begin
               if (pos_ff == '0 || steps_ff == SC_W'(ENTRIES)) begin
                  cp_ff <= '0;
                  if (next_free_ff == NF_W'(ENTRIES)) begin
                     res_index_ff   <= '0;
                     res_present_ff <= 1'b0;
                     res_status_ff  <= hstbl_pkg::STATUS_FULL;
                     done_ff        <= 1'b1;
                     state_ff       <= S_IDLE;
                  end else begin
                     state_ff <= S_INS;
                  end
               end else begin
                  cp_ff    <= BP_W'(1);
                  state_ff <= S_CMP;
               end
            end
            S_CMP: begin
               // len_q, link_q and char_q of position cp_ff-1 are valid
               if (len_q != nlen_ff ||
                   (cp_ff <= BP_W'(nlen_ff) && char_q != buf_char)) begin
                  pos_ff   <= link_q;
                  steps_ff <= steps_ff + 1'b1;
                  cp_ff    <= '0;
                  state_ff <= S_ENTRY;
               end else if (cp_ff >= BP_W'(nlen_ff)) begin
                  res_index_ff   <= hstbl_pkg::INDEX_W'(pos_ff);
                  res_present_ff <= 1'b1;
                  res_status_ff  <= hstbl_pkg::STATUS_OK;
                  done_ff        <= 1'b1;
                  state_ff       <= S_IDLE;
               end else begin
                  cp_ff <= cp_ff + 1'b1;
               end
            end
            S_INS: begin
               if (cp_ff >= BP_W'(nlen_ff)) begin
                  state_ff <= S_HEADWR;
               end else begin
                  cp_ff <= cp_ff + 1'b1;
               end
            end
            S_HEADWR: begin
               head_valid_ff[bucket_ff] <= 1'b1;
               next_free_ff   <= next_free_ff + 1'b1;
               res_index_ff   <= hstbl_pkg::INDEX_W'(nf_idx);
               res_present_ff <= 1'b0;
               res_status_ff  <= hstbl_pkg::STATUS_OK;
               done_ff        <= 1'b1;
               state_ff       <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/hashed_symbol_table_insert_lookup.sv
// Hashed symbol table, lookup-or-insert: top level with stream ports.
// Depends on hstbl_pkg, hstbl_name_acc and hstbl_engine.
//
// Usage: a name arrives on req_ one byte per transaction, req_tlast on its
// final byte. Non-final bytes are taken one per cycle (hash h*31+c, name
// buffered). On the final byte the block walks the bucket chain held in
// synchronous memories, comparing each visited entry's length and bytes;
// on a miss it sees the chain end, then an insert writes the name one byte
// a cycle and links it at the bucket head. A name too long is answered
// without a walk. One rsp_ transaction follows each name: index, found
// flag and status (ok, table full, name too long). While a name is being
// resolved or its result waits in the output register, req_tready is low;
// a stalled receiver simply holds the result. Reset empties all chains
// (bucket valid flags in flip-flops) and sets the next free entry to 1;
// no clearing pass.
`default_nettype none
module hashed_symbol_table_insert_lookup #(
   parameter int BUCKETS    = hstbl_pkg::BUCKETS_DEF,
   parameter int ENTRIES    = hstbl_pkg::ENTRIES_DEF,
   parameter int NAME_CHARS = hstbl_pkg::NAME_CHARS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] character
   input  wire logic        req_tlast,   // last_char
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // [7:0] entry_index, [8] already_present,
                                         // [10:9] status, [15:11] zero
);
   localparam int LEN_W = $clog2(NAME_CHARS + 2);

   logic busy_ff, rsp_valid_ff;
   logic [15:0] rsp_data_ff;
   logic take, fin;
   logic [hstbl_pkg::HASH_W-1:0] hash_next;
   logic [LEN_W-1:0] len_next;
   logic [$clog2(NAME_CHARS+1)-1:0] buf_pos;
   logic [hstbl_pkg::CHAR_W-1:0] buf_char;
   logic done, present;
   logic [hstbl_pkg::INDEX_W-1:0] idx;
   hstbl_pkg::status_type st;

   assign req_tready = !busy_ff && !rsp_valid_ff;
   assign take = req_tvalid && req_tready;
   assign fin  = take && req_tlast;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   hstbl_name_acc #(.NAME_CHARS(NAME_CHARS), .LEN_W(LEN_W)) u_acc (
      .clock, .reset, .take, .character(req_tdata), .clear(done),
      .rd_pos(buf_pos), .rd_char(buf_char), .hash_next, .len_next
   );

   hstbl_engine #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES), .NAME_CHARS(NAME_CHARS),
                  .LEN_W(LEN_W)) u_eng (
      .clock, .reset, .start(fin), .hash(hash_next), .name_len(len_next),
      .buf_pos, .buf_char, .done, .res_index(idx), .res_present(present),
      .res_status(st)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fin) busy_ff <= 1'b1;
         else if (done) busy_ff <= 1'b0;
         if (done) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
      if (done) rsp_data_ff <= {5'd0, st, present, idx};
   end
endmodule
`default_nettype wire

>>> bench/tb_hashed_symbol_table_insert_lookup.sv
// Testbench for hashed_symbol_table_insert_lookup: streams names in, predicts and checks results.
// Depends on hstbl_pkg and the RTL of the block; self-contained otherwise.
`default_nettype none
module tb_hashed_symbol_table_insert_lookup;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_BUCKETS   = hstbl_pkg::BUCKETS_DEF;
   localparam int N_ENTRIES   = hstbl_pkg::ENTRIES_DEF;
   localparam int MAX_CHARS   = hstbl_pkg::NAME_CHARS_DEF;
   localparam int ITEM_TARGET = 1350;
   localparam int IDLE_LIMIT  = 30000;   // cycles with no transaction on either side
   localparam int MAX_NAME    = 24;
   localparam int POOL_DEPTH  = 600;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;     // [7:0] character
   logic        req_tlast = 1'b0;   // last_char
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [7:0] entry_index, [8] already_present, [10:9] status

   int errors = 0;

   typedef struct {
      logic [7:0] index;
      logic       found;
      hstbl_pkg::status_type st;
   } lookup_result_type;

   typedef struct {
      logic [7:0] c [MAX_NAME];
      int         len;
   } name_type;

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // Scoreboard: own copy of the table, predicts each lookup, holds the results due.
   class symtab_scoreboard;
      logic [7:0]  heads [N_BUCKETS];
      logic [7:0]  links [N_ENTRIES];
      logic [4:0]  lens  [N_ENTRIES];
      logic [7:0]  chars [N_ENTRIES][MAX_CHARS];
      int          free_idx;
      logic [31:0] hash;
      logic [7:0]  buffer [MAX_CHARS];
      int          cur_len;
      lookup_result_type due [$];

      function new();
         foreach (heads[i]) heads[i] = '0;
         free_idx = 1;
         hash     = '0;
         cur_len  = 0;
      endfunction

      function int pending();
         return due.size();
      endfunction

      function bit same_name(int idx);
         if (lens[idx] != cur_len) return 0;
         for (int i = 0; i < cur_len; i++)
            if (chars[idx][i] != buffer[i]) return 0;
         return 1;
      endfunction

      function void note_input(logic [7:0] ch, logic last);
         lookup_result_type r;
         int bucket, pos, hit;
         hash = hash * hstbl_pkg::HASH_MULT + 32'(ch);
         if (cur_len < MAX_CHARS) buffer[cur_len] = ch;
         if (cur_len <= MAX_CHARS) cur_len++;
         if (!last) return;
         if (cur_len > MAX_CHARS) begin
            r = '{8'd0, 1'b0, hstbl_pkg::STATUS_TOO_LONG};
         end else begin
            bucket = int'(hash % N_BUCKETS);
            pos = heads[bucket];
            hit = 0;
            for (int steps = 0; pos != 0 && steps < N_ENTRIES; steps++) begin
               if (same_name(pos)) begin
                  hit = pos;
                  break;
               end
               pos = links[pos];
            end
            if (hit != 0) begin
               r = '{8'(hit), 1'b1, hstbl_pkg::STATUS_OK};
            end else if (free_idx >= N_ENTRIES) begin
               r = '{8'd0, 1'b0, hstbl_pkg::STATUS_FULL};
            end else begin
               for (int i = 0; i < cur_len; i++) chars[free_idx][i] = buffer[i];
               lens[free_idx]  = 5'(cur_len);
               links[free_idx] = heads[bucket];
               heads[bucket]   = 8'(free_idx);
               r = '{8'(free_idx), 1'b0, hstbl_pkg::STATUS_OK};
               free_idx++;
            end
         end
         due.push_back(r);
         hash    = '0;
         cur_len = 0;
      endfunction

      task check_result(logic [15:0] data);
         lookup_result_type w;
         if (due.size() == 0) begin
            report_mismatch("unexpected result, tdata", int'(data), 0);
            return;
         end
         w = due.pop_front();
         if (data[7:0] !== w.index)  report_mismatch("entry_index", int'(data[7:0]), int'(w.index));
         if (data[8] !== w.found)    report_mismatch("already_present", int'(data[8]), int'(w.found));
         if (data[10:9] !== w.st)    report_mismatch("status", int'(data[10:9]), int'(w.st));
         if (data[15:11] !== 5'd0)   report_mismatch("padding", int'(data[15:11]), 0);
      endtask
   endclass

   symtab_scoreboard sb = new();

   hashed_symbol_table_insert_lookup DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Monitor and watchdog, sampled at the rising edge.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_input(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
               $display("Regression FAIL");
               $finish;
            end
         end
      end
   end

   // Receiver: random back-pressure, calm stretches, and one long hold-off on request.
   bit hold_request = 0;
   bit calm_rx      = 0;
   initial begin
      int w;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready = 1'b0;
            repeat (400) @(negedge clock);
            hold_request = 0;
         end
         w = calm_rx ? 0 : $urandom_range(0, 5);
         if (w > 0) begin
            rsp_tready = 1'b0;
            repeat (w) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   // Sender side
   int  items_sent = 0;
   bit  calm_tx    = 0;
   name_type pool [POOL_DEPTH];
   int  pool_size = 0;

   task automatic send_char(input logic [7:0] ch, input logic last);
      int gap;
      gap = calm_tx ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = ch;
      req_tlast  = last;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_name(input name_type n);
      for (int i = 0; i < n.len; i++) send_char(n.c[i], i == n.len - 1);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   function automatic name_type make_name(int len, bit narrow);
      name_type n;
      n.len = len;
      // narrow alphabet gives near-miss names of equal length in shared chains
      for (int i = 0; i < len; i++)
         n.c[i] = narrow ? 8'($urandom_range(8'h41, 8'h43)) : 8'($urandom_range(1, 255));
      return n;
   endfunction

   task automatic send_directed(input name_type n);
      send_name(n);
      if (pool_size < POOL_DEPTH && n.len <= MAX_CHARS) begin
         pool[pool_size] = n;
         pool_size++;
      end
   endtask

   initial begin
      name_type n;
      int sel, len;
      bit held, paused;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: one-char names, repeat hit, top byte, name "0" twice, full-length name
      n.len = 1; n.c[0] = 8'h41;  send_directed(n);
      send_name(n);
      n.c[0] = 8'hFF;             send_directed(n);
      n.c[0] = 8'h01;             send_directed(n);
      n.c[0] = 8'h30;             send_directed(n);
      send_name(n);
      n.len = MAX_CHARS;
      for (int i = 0; i < MAX_CHARS; i++) n.c[i] = 8'(8'h80 >> (i % 8)) ^ 8'(i);
      send_directed(n);
      drain();

      held = 0;
      paused = 0;
      while (items_sent < ITEM_TARGET) begin
         if (!held && items_sent > 500) begin
            held = 1;
            hold_request = 1;   // receiver stalls while names keep coming
         end
         if (!paused && items_sent > 900) begin
            paused = 1;
            drain();
         end
         calm_tx = (items_sent % 300) < 40;
         calm_rx = (items_sent % 400) < 50;
         sel = $urandom_range(0, 99);
         if (sel < 35 && pool_size > 0) begin
            send_name(pool[$urandom_range(0, pool_size - 1)]);
         end else if (sel < 43) begin
            send_name(make_name($urandom_range(MAX_CHARS + 1, MAX_NAME), 0));
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, MAX_CHARS)
                                               : $urandom_range(1, 4);
            send_directed(make_name(len, $urandom_range(0, 2) == 0));
         end
      end
      req_tvalid = 1'b0;
      calm_rx = 0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (errors == 0 && !rsp_tvalid) begin
         $display("Regression PASS");
      end else begin
         if (rsp_tvalid) $display("result offered with none expected");
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> files.f
rtl/core/hstbl_pkg.sv
rtl/core/hstbl_name_acc.sv
rtl/core/hstbl_engine.sv
rtl/core/hashed_symbol_table_insert_lookup.sv
bench/tb_hashed_symbol_table_insert_lookup.sv
